// ===== hdl/dpwm_pkg.sv =====
// Shared constants, types and state codes for the distinct peer window max block.
// Depends on nothing; every module under hdl imports it.
`default_nettype none

package dpwm_pkg;

   localparam int ID_SLOTS      = 4;
   localparam int HISTORY_DEPTH = 4;
   localparam int ID_WIDTH      = 16;

   // Fixed widths of the stream fields
   localparam int PEER_ID_W  = 16;
   localparam int OUT_CNT_W  = 3;
   localparam int RSP_DATA_W = 8;

   // Per-cycle count, able to hold ID_SLOTS itself
   localparam int CNT_W  = $clog2(ID_SLOTS + 1);
   // Sequencer step bound for both cell rows to settle after an accept: the longer row
   localparam int STEPS  = (ID_SLOTS > HISTORY_DEPTH) ? ID_SLOTS : HISTORY_DEPTH;
   localparam int STEP_W = $clog2(STEPS + 1);

   typedef enum logic {
      FUNC_HEARD = 1'b0,
      FUNC_END   = 1'b1
   } dpwm_func_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } dpwm_state_type;

   // Probe that walks the ID cell row, one cell per cycle
   typedef struct packed {
      logic                valid;
      logic                done;
      logic [ID_WIDTH-1:0] id;
   } dpwm_token_type;

endpackage

`default_nettype wire

// ===== hdl/dpwm_id_cell.sv =====
// One slot of the peer ID table: holds an ID, checks the passing probe against it.
// Depends on dpwm_pkg.
`default_nettype none

module dpwm_id_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     clear,
   input  wire dpwm_pkg::dpwm_token_type tok_i,
   output dpwm_pkg::dpwm_token_type tok_o,
   output logic                    store_o
);
   import dpwm_pkg::*;

   dpwm_token_type      tok_ff;
   logic                occ_ff;
   logic                occ_in;
   logic [ID_WIDTH-1:0] id_ff;
   logic [ID_WIDTH-1:0] id_in;
   logic                hit;

   always_comb begin
      hit     = tok_ff.valid && !tok_ff.done && occ_ff && (id_ff == tok_ff.id);
      // first free slot reached with no match upstream: take the ID here
      store_o = tok_ff.valid && !tok_ff.done && !occ_ff;
      tok_o   = tok_ff;
      if (hit || store_o) begin
         tok_o.done = 1'b1;
      end
      occ_in = clear ? 1'b0 : (occ_ff || store_o);
      id_in  = store_o ? tok_ff.id : id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         occ_ff <= 1'b0;
      end else begin
         tok_ff <= tok_i;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule

`default_nettype wire

// ===== hdl/dpwm_hist_cell.sv =====
// One entry of the count history: shifts toward the oldest end, forwards a running max.
// Depends on dpwm_pkg.
`default_nettype none

module dpwm_hist_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         shift,
   input  wire  [dpwm_pkg::CNT_W-1:0]  cnt_i,
   input  wire  [dpwm_pkg::CNT_W-1:0]  pmax_i,
   output logic [dpwm_pkg::CNT_W-1:0]  cnt_o,
   output logic [dpwm_pkg::CNT_W-1:0]  pmax_o
);
   import dpwm_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] pmax_ff;
   logic [CNT_W-1:0] pmax_in;

   always_comb begin
      cnt_in  = shift ? cnt_i : cnt_ff;
      pmax_in = (cnt_ff > pmax_i) ? cnt_ff : pmax_i;
      cnt_o   = cnt_ff;
      pmax_o  = pmax_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pmax_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         pmax_ff <= pmax_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/distinct_peer_window_max.sv =====
// One item in flight: a new request is taken only once the response for the last one
// has been loaded; a stalled response holds off the next request. The sequencer waits
// for the probe walking the ID cell row one slot per cycle and for the running max
// rippling one history cell per cycle.
// Reset (synchronous, active high) clears the count, slot occupancy, the history window
// and the response valid flag; stored IDs and response data are not cleared.
`default_nettype none

module distinct_peer_window_max (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [dpwm_pkg::PEER_ID_W-1:0]      req_tdata,  // [15:0] peer_id
   input  wire                                 req_tuser,  // [0] func
   // response channel
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [dpwm_pkg::RSP_DATA_W-1:0]     rsp_tdata   // [2:0] distinct_now,
                                                           // [5:3] window_max,
                                                           // [6] anyone_present,
                                                           // [7] table_full
);
   import dpwm_pkg::*;

   dpwm_state_type           state_ff;
   dpwm_state_type           state_in;
   logic [STEP_W-1:0]        step_ff;
   logic [STEP_W-1:0]        step_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_in;

   logic                     req_xfer;
   logic                     end_xfer;
   logic                     finish;
   logic                     any_store;
   logic [ID_WIDTH+PEER_ID_W-1:0] id_ext;
   dpwm_token_type           inject;
   logic [CNT_W+OUT_CNT_W-1:0]    now_ext;
   logic [CNT_W+OUT_CNT_W-1:0]    max_ext;

   // cell rows
   dpwm_token_type           tok_chain [ID_SLOTS];
   logic [ID_SLOTS-1:0]      store_vec;
   logic [CNT_W-1:0]         cnt_chain  [HISTORY_DEPTH];
   logic [CNT_W-1:0]         pmax_chain [HISTORY_DEPTH];
   logic [CNT_W-1:0]         window_max;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign end_xfer   = req_xfer && (req_tuser == FUNC_END);

   // take the ID modulo 2^ID_WIDTH
   assign id_ext = {{ID_WIDTH{1'b0}}, req_tdata};

   always_comb begin
      inject.valid = req_xfer && (req_tuser == FUNC_HEARD);
      inject.done  = 1'b0;
      inject.id    = id_ext[ID_WIDTH-1:0];
   end

   // ID table: probe enters slot 0 and advances one slot per cycle
   genvar k;
   generate
      for (k = 0; k < ID_SLOTS; k++) begin : g_id
         dpwm_token_type tok_in_k;
         dpwm_token_type tok_out_k;
         if (k == 0) begin : g_first
            assign tok_in_k = inject;
         end else begin : g_rest
            assign tok_in_k = tok_chain[k-1];
         end
         dpwm_id_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .clear   (end_xfer),
            .tok_i   (tok_in_k),
            .tok_o   (tok_out_k),
            .store_o (store_vec[k])
         );
         assign tok_chain[k] = tok_out_k;
      end
   endgenerate

   assign any_store = |store_vec;

   // History window: newest at cell 0, oldest drops off the far end.
   // The running max ripples from cell 0 to the last cell, one cell per cycle.
   generate
      for (k = 0; k < HISTORY_DEPTH; k++) begin : g_hist
         logic [CNT_W-1:0] cnt_in_k;
         logic [CNT_W-1:0] pmax_in_k;
         if (k == 0) begin : g_first
            assign cnt_in_k  = count_ff;
            assign pmax_in_k = '0;
         end else begin : g_rest
            assign cnt_in_k  = cnt_chain[k-1];
            assign pmax_in_k = pmax_chain[k-1];
         end
         dpwm_hist_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .shift  (end_xfer),
            .cnt_i  (cnt_in_k),
            .pmax_i (pmax_in_k),
            .cnt_o  (cnt_chain[k]),
            .pmax_o (pmax_chain[k])
         );
      end
   endgenerate

   assign window_max = pmax_chain[HISTORY_DEPTH-1];

   // Distinct count: clear at end of cycle, advance when a slot takes a new ID
   always_comb begin
      if (end_xfer) begin
         count_in = '0;
      end else if (any_store) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Sequencer: step until step_ff reaches STEPS so both rows settle, then load the response
   assign finish = (state_ff == ST_RUN) && (step_ff == STEP_W'(STEPS))
                   && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end else if (step_ff != STEP_W'(STEPS)) begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: hold until transferred, refill when the sequencer finishes
   always_comb begin
      now_ext = {{OUT_CNT_W{1'b0}}, count_ff};
      max_ext = {{OUT_CNT_W{1'b0}}, window_max};
      rsp_data_in = rsp_data_ff;
      if (finish) begin
         rsp_data_in = {(count_ff == CNT_W'(ID_SLOTS)),
                        (window_max != '0),
                        max_ext[OUT_CNT_W-1:0],
                        now_ext[OUT_CNT_W-1:0]};
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for distinct_peer_window_max: heard and end-of-cycle transfers go in,
// and every status transfer is checked against an in-bench tally of peers and history.
// Depends on hdl/dpwm_pkg.sv and hdl/distinct_peer_window_max.sv.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dpwm_pkg::*;

   // One status transfer, laid out as rsp_tdata from the top bit down
   typedef struct packed {
      logic                 table_full;
      logic                 anyone_present;
      logic [OUT_CNT_W-1:0] window_max;
      logic [OUT_CNT_W-1:0] distinct_now;
   } peer_status_type;

   // Tracks peers heard in the open cycle and the per-cycle counts of the recent past,
   // and holds the status transfers still owed by the block, oldest first.
   class peer_tally_model;
      logic [ID_WIDTH-1:0] heard_ids[ID_SLOTS];
      int                  heard_count;
      int                  cycle_counts[HISTORY_DEPTH];
      peer_status_type     owed_status[$];
      int                  error_count;

      function new();
         heard_count = 0;
         error_count = 0;
         foreach (cycle_counts[i]) cycle_counts[i] = 0;
         foreach (heard_ids[i]) heard_ids[i] = '0;
      endfunction

      // Apply one accepted request; return 1 when a full table makes it a no-op
      function bit note_packet(dpwm_func_type func, logic [PEER_ID_W-1:0] peer_id);
         bit              dropped;
         bit              known;
         int              best;
         peer_status_type status;
         dropped = 1'b0;
         known   = 1'b0;
         best    = 0;
         if (func == FUNC_HEARD) begin
            if (heard_count >= ID_SLOTS) begin
               dropped = 1'b1;
            end else begin
               for (int i = 0; i < heard_count; i++)
                  if (heard_ids[i] == ID_WIDTH'(peer_id)) known = 1'b1;
               if (!known) begin
                  heard_ids[heard_count] = ID_WIDTH'(peer_id);
                  heard_count++;
               end
            end
         end else begin
            // shift the window toward the oldest slot and push the closing count
            for (int i = 0; i + 1 < HISTORY_DEPTH; i++) cycle_counts[i] = cycle_counts[i + 1];
            cycle_counts[HISTORY_DEPTH - 1] = heard_count;
            heard_count = 0;
         end
         foreach (cycle_counts[i]) if (cycle_counts[i] > best) best = cycle_counts[i];
         status.distinct_now   = OUT_CNT_W'(heard_count);
         status.window_max     = OUT_CNT_W'(best);
         status.anyone_present = (best != 0);
         status.table_full     = (heard_count >= ID_SLOTS);
         owed_status.push_back(status);
         return dropped;
      endfunction

      function int pending();
         return owed_status.size();
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
         error_count++;
      endtask

      task check_status(logic [RSP_DATA_W-1:0] data);
         peer_status_type got;
         peer_status_type want;
         got = data;
         if (owed_status.size() == 0) begin
            report_mismatch("unexpected status transfer", int'(data), -1);
         end else begin
            want = owed_status.pop_front();
            if (got.distinct_now != want.distinct_now)
               report_mismatch("distinct_now", got.distinct_now, want.distinct_now);
            if (got.window_max != want.window_max)
               report_mismatch("window_max", got.window_max, want.window_max);
            if (got.anyone_present != want.anyone_present)
               report_mismatch("anyone_present", got.anyone_present, want.anyone_present);
            if (got.table_full != want.table_full)
               report_mismatch("table_full", got.table_full, want.table_full);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PEER_ID_W-1:0]  req_tdata = '0;   // [15:0] peer_id
   logic                  req_tuser = 1'b0; // [0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [2:0] distinct_now, [5:3] window_max,
                                            // [6] anyone_present, [7] table_full

   peer_tally_model tally;
   int              burst_left;
   int              live_items;
   longint          ready_phase;

   distinct_peer_window_max dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver backpressure: rotate through always ready, coin flips, one-in-four
   // acceptance and long stalls so that stalls land on every phase of the block.
   initial ready_phase = 0;
   always @(negedge clock) begin
      ready_phase <= ready_phase + 1;
      case ((ready_phase / 256) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(1, 0));
         2: rsp_tready <= (ready_phase % 4 == 0);
         default: rsp_tready <= (ready_phase % 16 < 6);
      endcase
   end

   // Check every status transfer against the oldest owed status
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tally.check_status(rsp_tdata);
   end

   // Present one request at the falling edge and hold it until the transfer happens.
   // Valid stays high on return; the caller lowers it through idle_for or ends the run.
   task send_request(dpwm_func_type func, logic [PEER_ID_W-1:0] peer_id);
      bit dropped;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= peer_id;
      do @(posedge clock); while (!req_tready);
      dropped = tally.note_packet(func, peer_id);
      if (!dropped) live_items++;
   endtask

   task idle_for(int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= PEER_ID_W'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   // Hold off the sender until every owed status has come back
   task drain_status();
      idle_for(0);
      while (tally.pending() != 0) @(posedge clock);
   endtask

   // Sender pacing: bursts of random length, then a random gap; now and then
   // a long burst with no gaps at all.
   task pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         idle_for($urandom_range(8, 1));
         burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(80, 40) :
                                                    $urandom_range(24, 1);
      end
   endtask

   task send_paced(dpwm_func_type func, logic [PEER_ID_W-1:0] peer_id);
      send_request(func, peer_id);
      pace_sender();
   endtask

   // One well-formed radio cycle: a handful of heard packets drawn from a small
   // pool so repeats are common, then the end-of-cycle marker with junk in peer_id.
   task send_radio_cycle();
      logic [PEER_ID_W-1:0] pool[6];
      int                   pool_size;
      int                   packets;
      foreach (pool[i]) begin
         case ($urandom_range(5, 0))
            0: pool[i] = '0;
            1: pool[i] = '1;
            2: pool[i] = PEER_ID_W'(1) << $urandom_range(PEER_ID_W - 1, 0);
            default: pool[i] = PEER_ID_W'($urandom);
         endcase
      end
      pool_size = $urandom_range(6, 1);
      packets   = $urandom_range(8, 0);
      repeat (packets) send_paced(FUNC_HEARD, pool[$urandom_range(pool_size - 1, 0)]);
      send_paced(FUNC_END, PEER_ID_W'($urandom));
   endtask

   initial begin
      tally      = new();
      burst_left = 1;
      live_items = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fill the table with extreme IDs and a repeat, hit the full table
      // with a stored and a new ID, then close cycles until the window empties.
      send_paced(FUNC_HEARD, 16'h0000);
      send_paced(FUNC_HEARD, 16'h0000);
      send_paced(FUNC_HEARD, 16'hFFFF);
      send_paced(FUNC_HEARD, 16'h5555);
      send_paced(FUNC_HEARD, 16'hAAAA);
      send_paced(FUNC_HEARD, 16'h0000);
      send_paced(FUNC_HEARD, 16'h1234);
      send_paced(FUNC_END,   16'hFFFF);
      send_paced(FUNC_END,   16'h0000);
      send_paced(FUNC_HEARD, 16'h8000);
      send_paced(FUNC_HEARD, 16'h0001);
      send_paced(FUNC_HEARD, 16'h8000);
      send_paced(FUNC_END,   16'hA5A5);
      send_paced(FUNC_HEARD, 16'h7FFF);
      send_paced(FUNC_END,   16'h0000);
      send_paced(FUNC_END,   16'h0000);
      send_paced(FUNC_END,   16'h0000);
      send_paced(FUNC_END,   16'h0000);
      send_paced(FUNC_END,   16'h0000);
      drain_status();

      // Random: mostly well-formed cycles, some noise; drain now and then
      live_items = 0;
      while (live_items < 1700) begin
         if ($urandom_range(99, 0) < 85) begin
            send_radio_cycle();
         end else begin
            send_paced(dpwm_func_type'($urandom_range(1, 0)), PEER_ID_W'($urandom));
         end
         if ($urandom_range(60, 0) == 0) drain_status();
      end
      drain_status();
      repeat (20) @(posedge clock);

      if (tally.error_count == 0 && tally.pending() == 0) begin
         $display("distinct_peer_window_max regression: pass");
      end else begin
         $display("distinct_peer_window_max regression: fail");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #2ms;
      $display("distinct_peer_window_max regression: fail");
      $finish;
   end

endmodule
